// File: sv/bcpe_pkg.sv
// Package: shared types, constants and codes of the Bezier point evaluator.
`default_nettype none
package bcpe_pkg;
    // Store and coordinate geometry
    localparam int MAX_POINTS  = 8;
    localparam int PIDX_W      = $clog2(MAX_POINTS);   // index wraps by mask
    localparam int COORD_BITS  = 12;
    localparam int U_FRAC_BITS = 16;
    localparam int U_W         = U_FRAC_BITS + 1;
    localparam int MAX_DEGREE  = 6;
    localparam int DEG_W       = 3;
    localparam int INTER_FRAC  = 16;
    localparam int IW          = COORD_BITS + INTER_FRAC;
    localparam int OUT_FRAC    = 4;
    localparam int OUT_BITS    = 16;
    localparam int OUT_SHIFT   = INTER_FRAC - OUT_FRAC;
    localparam int PROD_W      = IW + 1 + U_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    typedef logic [CFG_IDX_W-1:0]         t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]        t_cfg_data;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [PIDX_W-1:0]            t_pidx;
    typedef logic [DEG_W-1:0]             t_deg;
    typedef logic [U_W-1:0]               t_u;
    typedef logic signed [IW-1:0]         t_w;
    typedef t_w [MAX_DEGREE:0]            t_wvec;
    typedef logic signed [OUT_BITS-1:0]   t_out;

    localparam t_cfg_idx REG_CURVE_DEGREE = t_cfg_idx'(0);
    localparam t_cfg_idx REG_CLOSED_CURVE = t_cfg_idx'(1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam t_deg DEG_RESET = t_deg'(3);
    localparam t_deg DEG_MIN   = t_deg'(1);
    localparam t_deg DEG_MAX   = t_deg'(MAX_DEGREE);
    localparam t_u   U_ONE     = t_u'(1) << U_FRAC_BITS;

    // Control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        t_deg deg;
        t_u   u;
    } t_ctl;
endpackage
`default_nettype wire

// File: sv/bcpe_if.sv
// Interfaces: input item channel and result channel.
`default_nettype none
interface bcpe_in_if;
    import bcpe_pkg::*;
    logic   valid;
    logic   ready;
    logic   operation;
    t_pidx  point_index;
    t_coord point_x;
    t_coord point_y;
    t_pidx  first_point;
    t_u     param_u;

    modport source (output valid, operation, point_index, point_x, point_y,
                    first_point, param_u, input ready);
    modport sink   (input valid, operation, point_index, point_x, point_y,
                    first_point, param_u, output ready);
endinterface

interface bcpe_out_if;
    import bcpe_pkg::*;
    logic valid;
    logic ready;
    t_out curve_x;
    t_out curve_y;

    modport source (output valid, curve_x, curve_y, input ready);
    modport sink   (input valid, curve_x, curve_y, output ready);
endinterface
`default_nettype wire

// File: sv/bezier_curve_point_evaluator.sv
// Top level: Bezier curve point evaluator, de Casteljau in a 9-stage pipeline.
// Order: the accepting edge loads stage 0; o_out.valid rises once an evaluate
//   transaction has passed stage 1, the lerp levels and the output register.
// Throughput: one transaction per cycle, loads and evaluates alike; a stall
//   at the output freezes the whole pipeline, one lerp level per stage.
// Reset (synchronous, active low): clears valid bits, degree 3, open curve;
//   the control point store is not cleared.
`default_nettype none
module bezier_curve_point_evaluator (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    bcpe_in_if.sink                  i_in,
    bcpe_out_if.source               o_out,
    input  wire logic                i_cfg_we,
    input  wire bcpe_pkg::t_cfg_idx  i_cfg_idx,
    input  wire bcpe_pkg::t_cfg_data i_cfg_data
);
    import bcpe_pkg::*;

    // Global advance: the output register is free or being drained
    logic  w_en;
    t_ctl  w_ctl [MAX_DEGREE+1];
    t_wvec w_wx  [MAX_DEGREE+1];
    t_wvec w_wy  [MAX_DEGREE+1];

    assign w_en = !o_out.valid || o_out.ready;

    // Store write on load transactions, snapshot and point selection
    bcpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (w_ctl[0]),
        .o_wx       (w_wx[0]),
        .o_wy       (w_wy[0])
    );

    // One interpolation level per stage; the first (6 - degree) stages pass
    // the points through unchanged.
    for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_level
        bcpe_lerp_stage u_lerp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_level (t_deg'(k + 1)),
            .i_ctl   (w_ctl[k]),
            .i_wx    (w_wx[k]),
            .i_wy    (w_wy[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_wx    (w_wx[k+1]),
            .o_wy    (w_wy[k+1])
        );
    end

    // Round to Q12.4 into the output register
    bcpe_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl[MAX_DEGREE]),
        .i_wx    (w_wx[MAX_DEGREE]),
        .i_wy    (w_wy[MAX_DEGREE]),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // A held result blocks new transactions
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");

    // Degree entering the lerp levels is clamped to the supported range
    a_degree_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[0].valid |-> (w_ctl[0].deg >= DEG_MIN && w_ctl[0].deg <= DEG_MAX))
        else $error("degree out of range in pipeline");

    // Parameter never exceeds 1.0 inside the pipeline
    a_u_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[0].valid |-> w_ctl[0].u <= U_ONE)
        else $error("u above one in pipeline");
`endif
endmodule
`default_nettype wire

// File: sv/bcpe_front.sv
// Front end: config registers, control point store, snapshot and point select.
`default_nettype none
module bcpe_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    bcpe_in_if.sink                  i_in,
    input  wire logic                i_cfg_we,
    input  wire bcpe_pkg::t_cfg_idx  i_cfg_idx,
    input  wire bcpe_pkg::t_cfg_data i_cfg_data,
    output bcpe_pkg::t_ctl           o_ctl,
    output bcpe_pkg::t_wvec          o_wx,
    output bcpe_pkg::t_wvec          o_wy
);
    import bcpe_pkg::*;

    t_deg   r_deg;
    logic   r_closed;
    t_coord r_px [MAX_POINTS];
    t_coord r_py [MAX_POINTS];

    // Stage 0: snapshot of the store plus clamped control
    logic   r_s0_valid;
    t_deg   r_s0_deg;
    t_u     r_s0_u;
    t_pidx  r_s0_base;
    logic   r_s0_closed;
    t_coord r_s0_px [MAX_POINTS];
    t_coord r_s0_py [MAX_POINTS];

    // Stage 1: selected, widened points
    t_ctl  r_s1_ctl;
    t_wvec r_s1_wx;
    t_wvec r_s1_wy;

    logic  w_accept;
    t_deg  n_deg;
    t_u    n_u;
    t_wvec n_wx;
    t_wvec n_wy;

    assign i_in.ready = i_en;
    assign w_accept   = i_in.valid && i_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg    <= DEG_RESET;
            r_closed <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CURVE_DEGREE: r_deg    <= i_cfg_data[DEG_W-1:0];
                REG_CLOSED_CURVE: r_closed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.operation == OP_LOAD) begin
            r_px[i_in.point_index] <= i_in.point_x;
            r_py[i_in.point_index] <= i_in.point_y;
        end
    end

    always_comb begin
        if (r_deg < DEG_MIN) begin
            n_deg = DEG_MIN;
        end else if (r_deg > DEG_MAX) begin
            n_deg = DEG_MAX;
        end else begin
            n_deg = r_deg;
        end
        n_u = (i_in.param_u > U_ONE) ? U_ONE : i_in.param_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_ctl   <= '0;
        end else if (i_en) begin
            r_s0_valid     <= w_accept && i_in.operation == OP_EVAL;
            r_s1_ctl.valid <= r_s0_valid;
            r_s1_ctl.deg   <= r_s0_deg;
            r_s1_ctl.u     <= r_s0_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_deg    <= n_deg;
            r_s0_u      <= n_u;
            r_s0_base   <= i_in.first_point;
            r_s0_closed <= r_closed;
            r_s0_px     <= r_px;
            r_s0_py     <= r_py;
            r_s1_wx     <= n_wx;
            r_s1_wy     <= n_wy;
        end
    end

    // Rotate the snapshot to the segment start; closed curves reuse the start
    always_comb begin
        t_pidx idx;
        for (int i = 0; i <= MAX_DEGREE; i++) begin
            idx = r_s0_base + t_pidx'(i);
            if (r_s0_closed && r_s0_deg == t_deg'(i)) begin
                idx = r_s0_base;
            end
            n_wx[i] = {r_s0_px[idx], {INTER_FRAC{1'b0}}};
            n_wy[i] = {r_s0_py[idx], {INTER_FRAC{1'b0}}};
        end
    end

    assign o_ctl = r_s1_ctl;
    assign o_wx  = r_s1_wx;
    assign o_wy  = r_s1_wy;
endmodule
`default_nettype wire

// File: sv/bcpe_lerp_stage.sv
// One de Casteljau level: lerps all adjacent pairs, or passes through if idle.
`default_nettype none
module bcpe_lerp_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire bcpe_pkg::t_deg  i_level,
    input  wire bcpe_pkg::t_ctl  i_ctl,
    input  wire bcpe_pkg::t_wvec i_wx,
    input  wire bcpe_pkg::t_wvec i_wy,
    output bcpe_pkg::t_ctl       o_ctl,
    output bcpe_pkg::t_wvec      o_wx,
    output bcpe_pkg::t_wvec      o_wy
);
    import bcpe_pkg::*;

    t_ctl  r_ctl;
    t_wvec r_wx;
    t_wvec r_wy;
    t_wvec n_wx;
    t_wvec n_wy;
    logic  w_active;

    // a + round((b - a) * u / 2^U), ties up; equals the weighted form exactly
    function automatic t_w mix(input t_w a, input t_w b, input t_u u);
        logic signed [IW:0]       diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [IW:0]       step;
        logic signed [IW:0]       sum;
        diff = {b[IW-1], b} - {a[IW-1], a};
        prod = diff * $signed({1'b0, u});
        prod = prod + $signed(PROD_W'(1) << (U_FRAC_BITS - 1));
        step = prod[U_FRAC_BITS+IW:U_FRAC_BITS];
        sum  = {a[IW-1], a} + step;
        return sum[IW-1:0];
    endfunction

    // Lower degrees skip the leading levels
    assign w_active = i_level > (DEG_MAX - i_ctl.deg);

    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            n_wx[i] = w_active ? mix(i_wx[i], i_wx[i+1], i_ctl.u) : i_wx[i];
            n_wy[i] = w_active ? mix(i_wy[i], i_wy[i+1], i_ctl.u) : i_wy[i];
        end
        n_wx[MAX_DEGREE] = i_wx[MAX_DEGREE];
        n_wy[MAX_DEGREE] = i_wy[MAX_DEGREE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= n_wx;
            r_wy <= n_wy;
        end
    end

    assign o_ctl = r_ctl;
    assign o_wx  = r_wx;
    assign o_wy  = r_wy;
endmodule
`default_nettype wire

// File: sv/bcpe_round.sv
// Output stage: rounds to Q12.4 and holds the result transaction.
`default_nettype none
module bcpe_round (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire bcpe_pkg::t_ctl  i_ctl,
    input  wire bcpe_pkg::t_wvec i_wx,
    input  wire bcpe_pkg::t_wvec i_wy,
    bcpe_out_if.source           o_out
);
    import bcpe_pkg::*;

    logic             r_valid;
    t_out             r_x;
    t_out             r_y;
    logic signed [IW:0] w_rx;
    logic signed [IW:0] w_ry;

    assign w_rx = {i_wx[0][IW-1], i_wx[0]} + $signed((IW+1)'(1) << (OUT_SHIFT - 1));
    assign w_ry = {i_wy[0][IW-1], i_wy[0]} + $signed((IW+1)'(1) << (OUT_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= w_rx[OUT_SHIFT+OUT_BITS-1:OUT_SHIFT];
            r_y <= w_ry[OUT_SHIFT+OUT_BITS-1:OUT_SHIFT];
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.curve_x = r_x;
    assign o_out.curve_y = r_y;
endmodule
`default_nettype wire
